/* hdl/tpsd_pkg.sv */
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder: port words,
// the decoded pixel and the command word that runs between front and back.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    // Status codes of a result word
    localparam logic [1:0] ST_PIXELS = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    // Channel counts
    localparam logic [2:0] CHAN_RGB  = 3'd3;
    localparam logic [2:0] CHAN_RGBA = 3'd4;

    // Header values
    localparam logic [7:0] RLE_KIND = 8'd10;
    localparam logic [7:0] BPP_16   = 8'd16;
    localparam logic [7:0] BPP_24   = 8'd24;
    localparam logic [7:0] BPP_32   = 8'd32;
    localparam logic [4:0] HDR_LAST = 5'd16;

    // Packet head: codes at or above this start a repeat run
    localparam logic [7:0] PKT_REPEAT = 8'd128;
    localparam logic [7:0] PKT_BIAS   = 8'd127;

    // 5-5-5 field mask
    localparam logic [4:0] MASK_555 = 5'h1f;

    // Pixel slots in one result word
    localparam int unsigned GROUP = 2;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       new_file;
    } t_in_word;

    typedef struct packed {
        logic [1:0] pixel_count;
        logic [7:0] red_a;
        logic [7:0] green_a;
        logic [7:0] blue_a;
        logic [7:0] alpha_a;
        logic [7:0] red_b;
        logic [7:0] green_b;
        logic [7:0] blue_b;
        logic [7:0] alpha_b;
        logic [2:0] channel_count;
        logic [1:0] status;
        logic       last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    // One command per input byte that gives results. run_len 0 gives a
    // single status-only result.
    typedef struct packed {
        logic [7:0] run_len;
        t_pixel     pixel;
        logic [2:0] chan;
        logic [1:0] status;
    } t_cmd;

endpackage

/* hdl/tga_pixel_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_unit
// TGA byte stream to RGB(A) pixel word decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_word) takes one file byte a word;
//   set new_file on the first byte of each file to restart the parse.
//   Output channel (o_valid / i_ready / o_word) gives result words of up to
//   two pixels, with status and a last_of_run flag on the final word that a
//   byte causes. Header and skipped bytes mostly give no word at all.
//   Throughput: the parser takes one byte a cycle while the command queue
//   has room. The generator fetches a command when idle and then gives one
//   result word a cycle while the receiver takes them; it takes the next
//   command only after the final word of the last, so it sets the rate.
//   The first word of a byte passes through the queue and the generator's
//   command register into the output register.
//   Reset (synchronous, active low) returns the parser to header byte 0 and
//   empties the queue and the output stage.
//   A stalled receiver holds the output word; the generator halts, the queue
//   fills and o_ready then drops until space frees.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tpsd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output tpsd_pkg::t_out_word o_word
);

    // Commands from parser to generator
    logic           push;
    tpsd_pkg::t_cmd push_cmd;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    tpsd_pkg::t_cmd q_cmd;

    // Front: header parse, id skip, pixel assembly, run clipping
    tpsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_word   (i_word),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Queue: decouple byte intake from word output
    tpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: expand each command into result words
    tpsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_word    (o_word)
    );

endmodule

/* hdl/tpsd_front.sv */
// ----------------------------------------------------------------------------
// tpsd_front
// Byte parser: header, id skip, raw and RLE pixel assembly. Emits at most
// one command per accepted byte into the queue.
// ----------------------------------------------------------------------------
module tpsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tpsd_pkg::t_in_word i_word,
    input  logic              i_q_full,
    output logic              o_push,
    output tpsd_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_SKIP     = 7'b0000010,
        PH_RAW      = 7'b0000100,
        PH_PKT_HEAD = 7'b0001000,
        PH_PKT_BODY = 7'b0010000,
        PH_DONE     = 7'b0100000,
        PH_ERROR    = 7'b1000000
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [4:0]   r_hdr_idx, n_hdr_idx;
    logic [8:0]   r_skip_left, n_skip_left;
    logic [7:0]   r_id_len, n_id_len;
    logic [7:0]   r_kind, n_kind;
    logic [15:0]  r_width, n_width;
    logic [15:0]  r_height, n_height;
    logic [7:0]   r_bpp, n_bpp;
    logic [31:0]  r_pix_left, n_pix_left;
    logic [7:0]   r_pkt_left, n_pkt_left;
    logic         r_pkt_rep, n_pkt_rep;
    logic [31:0]  r_colour, n_colour;
    logic [1:0]   r_byte_idx, n_byte_idx;

    logic         accept;

    function automatic tpsd_pkg::t_pixel decode(input logic [31:0] v, input logic [7:0] bpp);
        tpsd_pkg::t_pixel p;
        if (bpp == tpsd_pkg::BPP_16) begin
            p.blue  = {v[4:0] & tpsd_pkg::MASK_555, 3'b000};
            p.green = {v[9:5] & tpsd_pkg::MASK_555, 3'b000};
            p.red   = {v[14:10] & tpsd_pkg::MASK_555, 3'b000};
            p.alpha = 8'd0;
        end else begin
            p.blue  = v[7:0];
            p.green = v[15:8];
            p.red   = v[23:16];
            p.alpha = (bpp == tpsd_pkg::BPP_32) ? v[31:24] : 8'd0;
        end
        return p;
    endfunction

    function automatic logic [2:0] chan_of(input logic [7:0] bpp);
        return (bpp == tpsd_pkg::BPP_32) ? tpsd_pkg::CHAN_RGBA : tpsd_pkg::CHAN_RGB;
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        t_phase      ph;
        logic [4:0]  idx;
        logic [7:0]  bpc;
        logic        ok;
        logic        px_done;
        logic [7:0]  run;
        logic [31:0] left_after;

        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_skip_left = r_skip_left;
        n_id_len    = r_id_len;
        n_kind      = r_kind;
        n_width     = r_width;
        n_height    = r_height;
        n_bpp       = r_bpp;
        n_pix_left  = r_pix_left;
        n_pkt_left  = r_pkt_left;
        n_pkt_rep   = r_pkt_rep;
        n_colour    = r_colour;
        n_byte_idx  = r_byte_idx;
        o_push      = 1'b0;
        o_cmd       = '0;
        ph          = r_phase;
        idx         = r_hdr_idx;
        bpc         = 8'd3;
        ok          = 1'b0;
        px_done     = 1'b0;
        run         = 8'd0;
        left_after  = 32'd0;

        if (accept) begin
            // New file: drop all parse state before taking this byte
            if (i_word.new_file) begin
                ph          = PH_HEADER;
                idx         = 5'd0;
                n_skip_left = '0;
                n_id_len    = '0;
                n_kind      = '0;
                n_width     = '0;
                n_height    = '0;
                n_bpp       = '0;
                n_pix_left  = '0;
                n_pkt_left  = '0;
                n_pkt_rep   = 1'b0;
                n_colour    = '0;
                n_byte_idx  = '0;
            end
            n_phase   = ph;
            n_hdr_idx = idx;

            // Pixel byte collection, used by the raw and packet body phases
            if (n_bpp == tpsd_pkg::BPP_16) begin
                bpc = 8'd2;
            end else if (n_bpp == tpsd_pkg::BPP_32) begin
                bpc = 8'd4;
            end else begin
                bpc = 8'd3;
            end

            case (ph)
                PH_HEADER: begin
                    case (idx)
                        5'd0:  n_id_len = i_word.file_byte;
                        5'd2:  n_kind   = i_word.file_byte;
                        5'd12: n_width  = {n_width[15:8], i_word.file_byte};
                        5'd13: n_width  = {i_word.file_byte, n_width[7:0]};
                        5'd14: n_height = {n_height[15:8], i_word.file_byte};
                        5'd15: n_height = {i_word.file_byte, n_height[7:0]};
                        5'd16: n_bpp    = i_word.file_byte;
                        default: ;
                    endcase
                    if (idx >= tpsd_pkg::HDR_LAST) begin
                        n_hdr_idx   = 5'd0;
                        n_skip_left = {1'b0, n_id_len} + 9'd1;
                        n_phase     = PH_SKIP;
                    end else begin
                        n_hdr_idx = idx + 5'd1;
                    end
                end
                PH_SKIP: begin
                    if (n_skip_left != 9'd0) begin
                        n_skip_left = n_skip_left - 9'd1;
                    end
                    if (n_skip_left == 9'd0) begin
                        if (n_kind != tpsd_pkg::RLE_KIND) begin
                            ok = (n_bpp == tpsd_pkg::BPP_16) || (n_bpp == tpsd_pkg::BPP_24)
                                || (n_bpp == tpsd_pkg::BPP_32);
                        end else begin
                            ok = (n_bpp == tpsd_pkg::BPP_24) || (n_bpp == tpsd_pkg::BPP_32);
                        end
                        if (!ok) begin
                            n_phase      = PH_ERROR;
                            n_bpp        = tpsd_pkg::BPP_24;
                            o_push       = 1'b1;
                            o_cmd.chan   = tpsd_pkg::CHAN_RGB;
                            o_cmd.status = tpsd_pkg::ST_ERROR;
                        end else begin
                            n_pix_left = 32'(n_width) * 32'(n_height);
                            n_colour   = '0;
                            n_byte_idx = '0;
                            if (n_width == 16'd0 || n_height == 16'd0) begin
                                n_phase      = PH_DONE;
                                o_push       = 1'b1;
                                o_cmd.chan   = chan_of(n_bpp);
                                o_cmd.status = tpsd_pkg::ST_DONE;
                            end else if (n_kind == tpsd_pkg::RLE_KIND) begin
                                n_phase = PH_PKT_HEAD;
                            end else begin
                                n_phase = PH_RAW;
                            end
                        end
                    end
                end
                PH_PKT_HEAD: begin
                    if (i_word.file_byte < tpsd_pkg::PKT_REPEAT) begin
                        n_pkt_rep  = 1'b0;
                        n_pkt_left = i_word.file_byte + 8'd1;
                    end else begin
                        n_pkt_rep  = 1'b1;
                        n_pkt_left = i_word.file_byte - tpsd_pkg::PKT_BIAS;
                    end
                    n_colour   = '0;
                    n_byte_idx = '0;
                    n_phase    = PH_PKT_BODY;
                end
                PH_RAW, PH_PKT_BODY: begin
                    n_colour = n_colour | (32'(i_word.file_byte) << {n_byte_idx, 3'b000});
                    px_done  = ({6'd0, n_byte_idx} + 8'd1) >= bpc;
                    if (px_done) begin
                        n_byte_idx  = '0;
                        o_push      = 1'b1;
                        o_cmd.pixel = decode(n_colour, n_bpp);
                        o_cmd.chan  = chan_of(n_bpp);
                        if (ph == PH_PKT_BODY && n_pkt_rep) begin
                            // Clip the run to the pixels still owed
                            run = (n_pix_left < {24'd0, n_pkt_left}) ? n_pix_left[7:0]
                                                                    : n_pkt_left;
                        end else begin
                            run = 8'd1;
                        end
                        left_after    = n_pix_left - {24'd0, run};
                        n_pix_left    = left_after;
                        n_colour      = '0;
                        o_cmd.run_len = run;
                        o_cmd.status  = (left_after == 32'd0) ? tpsd_pkg::ST_DONE
                                                              : tpsd_pkg::ST_PIXELS;
                        if (ph == PH_PKT_BODY) begin
                            n_pkt_left = n_pkt_rep ? 8'd0 : n_pkt_left - 8'd1;
                        end
                        if (left_after == 32'd0) begin
                            n_phase = PH_DONE;
                        end else if (ph == PH_PKT_BODY &&
                                     (n_pkt_rep || n_pkt_left == 8'd0)) begin
                            n_phase = PH_PKT_HEAD;
                        end
                    end else begin
                        n_byte_idx = n_byte_idx + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_idx   <= '0;
            r_skip_left <= '0;
            r_id_len    <= '0;
            r_kind      <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_bpp       <= '0;
            r_pix_left  <= '0;
            r_pkt_left  <= '0;
            r_pkt_rep   <= 1'b0;
            r_colour    <= '0;
            r_byte_idx  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_skip_left <= n_skip_left;
            r_id_len    <= n_id_len;
            r_kind      <= n_kind;
            r_width     <= n_width;
            r_height    <= n_height;
            r_bpp       <= n_bpp;
            r_pix_left  <= n_pix_left;
            r_pkt_left  <= n_pkt_left;
            r_pkt_rep   <= n_pkt_rep;
            r_colour    <= n_colour;
            r_byte_idx  <= n_byte_idx;
        end
    end

endmodule

/* hdl/tpsd_queue.sv */
// ----------------------------------------------------------------------------
// tpsd_queue
// Short command queue between parser and result generator.
// ----------------------------------------------------------------------------
module tpsd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpsd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tpsd_pkg::t_cmd o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tpsd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> (r_count == CW'(DEPTH)))
        else $error("queue left full state without a pop");

endmodule

/* hdl/tpsd_back.sv */
// ----------------------------------------------------------------------------
// tpsd_back
// Result generator: expands one command into result words, two pixel slots
// a word, into a registered output stage.
// ----------------------------------------------------------------------------
module tpsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tpsd_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output tpsd_pkg::t_out_word o_word
);

    logic                r_active;
    tpsd_pkg::t_cmd      r_cmd;
    logic [7:0]          r_left;
    logic                r_ovalid;
    tpsd_pkg::t_out_word r_out;

    logic                advance;
    logic                last;
    logic [1:0]          cnt;
    tpsd_pkg::t_out_word gen;

    assign o_pop   = !r_active && i_q_valid;
    assign advance = r_active && (!r_ovalid || i_ready);
    assign last    = r_left <= 8'(tpsd_pkg::GROUP);
    assign cnt     = last ? r_left[1:0] : 2'(tpsd_pkg::GROUP);

    always_comb begin
        gen               = '0;
        gen.pixel_count   = cnt;
        if (cnt >= 2'd1) begin
            gen.red_a   = r_cmd.pixel.red;
            gen.green_a = r_cmd.pixel.green;
            gen.blue_a  = r_cmd.pixel.blue;
            gen.alpha_a = r_cmd.pixel.alpha;
        end
        if (cnt >= 2'd2) begin
            gen.red_b   = r_cmd.pixel.red;
            gen.green_b = r_cmd.pixel.green;
            gen.blue_b  = r_cmd.pixel.blue;
            gen.alpha_b = r_cmd.pixel.alpha;
        end
        gen.channel_count = r_cmd.chan;
        gen.status        = last ? r_cmd.status : tpsd_pkg::ST_PIXELS;
        gen.last_of_run   = last;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (advance) begin
            r_out <= gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_left   <= i_q_cmd.run_len;
            end else if (advance) begin
                r_left <= r_left - {6'd0, cnt};
                if (last) begin
                    r_active <= 1'b0;
                end
            end
            if (advance) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_out;

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.status != tpsd_pkg::ST_PIXELS) |-> r_out.last_of_run)
        else $error("status word not last of its run");

    a_empty_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.pixel_count == 2'd0) |-> r_out.last_of_run)
        else $error("empty word not last of its run");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && last) |=> !r_active)
        else $error("generator still busy after final word");

endmodule

/* sim/tpsd_stream_check.sv */
// ----------------------------------------------------------------------------
// tpsd_stream_check
// Watches both channels of the TGA pixel stream decoder, decodes every byte
// taken in its own copy of the parser and compares the words that come out.
// ----------------------------------------------------------------------------
module tpsd_stream_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tpsd_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tpsd_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_RAW,
        PH_PKT_HEAD,
        PH_PKT_BODY,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // Header byte positions that carry parsed fields
    localparam logic [4:0] HDR_ID_LEN = 5'd0;
    localparam logic [4:0] HDR_KIND   = 5'd2;
    localparam logic [4:0] HDR_W_LO   = 5'd12;
    localparam logic [4:0] HDR_W_HI   = 5'd13;
    localparam logic [4:0] HDR_H_LO   = 5'd14;
    localparam logic [4:0] HDR_H_HI   = 5'd15;

    localparam int MAX_WORDS  = 64;
    localparam int MAX_REPORT = 10;

    t_phase      phase;
    logic [4:0]  hdr_idx;
    logic [8:0]  skip_cnt;
    logic [7:0]  id_len;
    logic [7:0]  img_kind;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  bpp;
    logic [31:0] px_left;
    logic [7:0]  pkt_left;
    logic        pkt_repeat;
    logic [31:0] colour;
    logic [1:0]  byte_pos;

    tpsd_pkg::t_out_word expected_words[$];
    int                  fault_count = 0;

    assign o_fail_count = fault_count;

    function automatic void clear_parse();
        phase      = PH_HEADER;
        hdr_idx    = '0;
        skip_cnt   = '0;
        id_len     = '0;
        img_kind   = '0;
        img_w      = '0;
        img_h      = '0;
        bpp        = '0;
        px_left    = '0;
        pkt_left   = '0;
        pkt_repeat = 1'b0;
        colour     = '0;
        byte_pos   = '0;
    endfunction

    function automatic tpsd_pkg::t_pixel unpack_pixel();
        tpsd_pkg::t_pixel p;
        p.alpha = '0;
        if (bpp == tpsd_pkg::BPP_16) begin
            p.blue  = {colour[4:0], 3'b000};
            p.green = {colour[9:5], 3'b000};
            p.red   = {colour[14:10], 3'b000};
        end else begin
            p.blue  = colour[7:0];
            p.green = colour[15:8];
            p.red   = colour[23:16];
            if (bpp == tpsd_pkg::BPP_32) p.alpha = colour[31:24];
        end
        return p;
    endfunction

    function automatic void queue_word(int unsigned cnt, tpsd_pkg::t_pixel px, logic [1:0] st);
        tpsd_pkg::t_out_word w;
        w = '0;
        w.pixel_count = 2'(cnt);
        if (cnt > 0) begin
            w.red_a   = px.red;
            w.green_a = px.green;
            w.blue_a  = px.blue;
            w.alpha_a = px.alpha;
        end
        if (cnt > 1) begin
            w.red_b   = px.red;
            w.green_b = px.green;
            w.blue_b  = px.blue;
            w.alpha_b = px.alpha;
        end
        w.channel_count = (bpp == tpsd_pkg::BPP_32) ? tpsd_pkg::CHAN_RGBA : tpsd_pkg::CHAN_RGB;
        w.status        = st;
        expected_words.push_back(w);
    endfunction

    // Gather one byte of a pixel, little end first; true once the pixel is whole
    function automatic bit collect_byte(logic [7:0] b);
        int unsigned width;
        width  = (bpp == tpsd_pkg::BPP_16) ? 2 : (bpp == tpsd_pkg::BPP_32) ? 4 : 3;
        colour = colour | (32'(b) << (8 * byte_pos));
        if (int'(byte_pos) + 1 >= width) begin
            byte_pos = '0;
            return 1'b1;
        end
        byte_pos = byte_pos + 2'd1;
        return 1'b0;
    endfunction

    function automatic void send_single();
        tpsd_pkg::t_pixel px;
        px      = unpack_pixel();
        colour  = '0;
        px_left = px_left - 32'd1;
        queue_word(1, px, (px_left == 0) ? tpsd_pkg::ST_DONE : tpsd_pkg::ST_PIXELS);
        if (px_left == 0) phase = PH_DONE;
    endfunction

    function automatic void decode_byte(tpsd_pkg::t_in_word w);
        logic [7:0]       b;
        int unsigned      held;
        bit               ok;
        tpsd_pkg::t_pixel px;
        logic [31:0]      run;
        int unsigned      take;
        int               words;
        b    = w.file_byte;
        held = expected_words.size();
        if (w.new_file) clear_parse();
        case (phase)
            PH_HEADER: begin
                case (hdr_idx)
                    HDR_ID_LEN:         id_len = b;
                    HDR_KIND:           img_kind = b;
                    HDR_W_LO:           img_w[7:0] = b;
                    HDR_W_HI:           img_w[15:8] = b;
                    HDR_H_LO:           img_h[7:0] = b;
                    HDR_H_HI:           img_h[15:8] = b;
                    tpsd_pkg::HDR_LAST: bpp = b;
                    default: ;
                endcase
                if (hdr_idx >= tpsd_pkg::HDR_LAST) begin
                    hdr_idx  = '0;
                    skip_cnt = 9'(id_len) + 9'd1;
                    phase    = PH_SKIP;
                end else begin
                    hdr_idx = hdr_idx + 5'd1;
                end
            end
            PH_SKIP: begin
                if (skip_cnt > 0) skip_cnt = skip_cnt - 9'd1;
                if (skip_cnt == 0) begin
                    if (img_kind != tpsd_pkg::RLE_KIND)
                        ok = (bpp == tpsd_pkg::BPP_16 || bpp == tpsd_pkg::BPP_24 ||
                              bpp == tpsd_pkg::BPP_32);
                    else
                        ok = (bpp == tpsd_pkg::BPP_24 || bpp == tpsd_pkg::BPP_32);
                    if (!ok) begin
                        // error word always reports three channels
                        phase = PH_ERROR;
                        bpp   = tpsd_pkg::BPP_24;
                        queue_word(0, '0, tpsd_pkg::ST_ERROR);
                    end else begin
                        px_left  = 32'(img_w) * 32'(img_h);
                        colour   = '0;
                        byte_pos = '0;
                        if (px_left == 0) begin
                            phase = PH_DONE;
                            queue_word(0, '0, tpsd_pkg::ST_DONE);
                        end else begin
                            phase = (img_kind == tpsd_pkg::RLE_KIND) ? PH_PKT_HEAD : PH_RAW;
                        end
                    end
                end
            end
            PH_RAW: begin
                if (collect_byte(b)) send_single();
            end
            PH_PKT_HEAD: begin
                if (b < tpsd_pkg::PKT_REPEAT) begin
                    pkt_repeat = 1'b0;
                    pkt_left   = b + 8'd1;
                end else begin
                    pkt_repeat = 1'b1;
                    pkt_left   = b - tpsd_pkg::PKT_BIAS;
                end
                colour   = '0;
                byte_pos = '0;
                phase    = PH_PKT_BODY;
            end
            PH_PKT_BODY: begin
                if (collect_byte(b)) begin
                    if (pkt_repeat) begin
                        // clip the run to what is left, pack two pixels a word
                        px     = unpack_pixel();
                        colour = '0;
                        run    = 32'(pkt_left);
                        words  = 0;
                        if (run > px_left) run = px_left;
                        while (run > 0 && words < MAX_WORDS) begin
                            take    = (run < tpsd_pkg::GROUP) ? run : tpsd_pkg::GROUP;
                            px_left = px_left - take;
                            run     = run - take;
                            queue_word(take, px, (px_left == 0) ? tpsd_pkg::ST_DONE
                                                                : tpsd_pkg::ST_PIXELS);
                            words++;
                        end
                        pkt_left = '0;
                        phase    = (px_left == 0) ? PH_DONE : PH_PKT_HEAD;
                    end else begin
                        send_single();
                        pkt_left = pkt_left - 8'd1;
                        if (phase != PH_DONE && pkt_left == 0) phase = PH_PKT_HEAD;
                    end
                end
            end
            default: ;
        endcase
        if (expected_words.size() > held)
            expected_words[expected_words.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic string word_text(tpsd_pkg::t_out_word w);
        return {$sformatf("cnt=%0d a=%02h/%02h/%02h/%02h ", w.pixel_count,
                          w.red_a, w.green_a, w.blue_a, w.alpha_a),
                $sformatf("b=%02h/%02h/%02h/%02h ch=%0d st=%0d last=%0b",
                          w.red_b, w.green_b, w.blue_b, w.alpha_b,
                          w.channel_count, w.status, w.last_of_run)};
    endfunction

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORT) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin
        tpsd_pkg::t_out_word want;
        if (!i_rst_n) begin
            clear_parse();
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    note_fault($sformatf("unexpected word: %s", word_text(i_out_word)));
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_word !== want)
                        note_fault($sformatf("mismatch: expected %s\n          actual   %s",
                                             word_text(want), word_text(i_out_word)));
                end
            end
            if (i_in_valid && i_in_ready) decode_byte(i_in_word);
        end
        o_pending <= expected_words.size();
    end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Regression bench for the TGA pixel stream decoder: feeds whole TGA files
// (raw 16/24/32-bit, RLE, empty, unsupported, cut short) byte by byte under
// varying back-pressure and lets the stream checker judge every result word.
// ----------------------------------------------------------------------------
module tb;

    // Image type for uncompressed true-colour data
    localparam logic [7:0] RAW_KIND = 8'd2;

    // Stop feeding new files once roughly this many bytes have gone in
    localparam int BYTE_TARGET = 344;
    // Cycles to wait for stray words once nothing is expected
    localparam int TAIL_CYCLES = 40;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    tpsd_pkg::t_in_word  i_word  = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    tpsd_pkg::t_out_word o_word;

    int fail_count;
    int pending;

    // Percentages of cycles with the sender idle and the receiver stalling
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int         bytes_sent = 0;
    logic [7:0] file_bytes[$];

    always #6 i_clk = ~i_clk;

    tga_pixel_stream_decoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    tpsd_stream_check stream_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_word    (i_word),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: stall at random, one fresh decision every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one word; idle first at random, then hold valid and payload until taken
    task automatic send_word(input logic [7:0] b, input logic nf);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= '{file_byte: b, new_file: nf};
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // Append the 17 header bytes, the descriptor and the id field
    task automatic put_header(input logic [7:0] kind, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth,
                              input logic [7:0] id_bytes);
        file_bytes.push_back(id_bytes);
        file_bytes.push_back(8'($urandom));            // colour map type, ignored
        file_bytes.push_back(kind);
        repeat (9) file_bytes.push_back(8'($urandom)); // colour map spec and origin
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(depth);
        repeat (int'(id_bytes) + 1) file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_pixel(input logic [7:0] depth);
        repeat ((depth == tpsd_pkg::BPP_16) ? 2 : (depth == tpsd_pkg::BPP_32) ? 4 : 3)
            file_bytes.push_back(8'($urandom));
    endtask

    // Send the assembled file; only its first byte may carry new_file
    task automatic play_file(input logic first_nf);
        foreach (file_bytes[k]) send_word(file_bytes[k], (k == 0) ? first_nf : 1'b0);
        file_bytes.delete();
    endtask

    initial begin
        logic [7:0]  kind;
        logic [7:0]  depth;
        logic [7:0]  id_bytes;
        logic [15:0] w;
        logic [15:0] h;
        int unsigned total;
        int unsigned left;
        int unsigned cnt;
        int unsigned roll;
        int unsigned file_no;
        bit          supported;

        // Hold reset, then release it once
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed file straight after reset, without new_file: 32-bit RLE,
        // three pixels covered by one repeat of 128, so the run is clipped and
        // packed two then one; the last word marks the image complete.
        put_header(tpsd_pkg::RLE_KIND, 16'd3, 16'd1, tpsd_pkg::BPP_32, 8'd0);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        play_file(1'b0);
        // Drop a byte after completion: no word may follow
        send_word(8'hFF, 1'b0);

        // Random files, rotating through the back-pressure phases
        for (file_no = 0; bytes_sent < BYTE_TARGET; file_no++) begin
            case (file_no % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase

            roll = $urandom_range(99);
            kind = (roll < 45) ? tpsd_pkg::RLE_KIND : (roll < 85) ? RAW_KIND : 8'($urandom);
            roll = $urandom_range(99);
            depth = (roll < 30) ? tpsd_pkg::BPP_24 : (roll < 60) ? tpsd_pkg::BPP_32 :
                    (roll < 82) ? tpsd_pkg::BPP_16 : 8'($urandom);
            id_bytes = 8'($urandom_range(3));

            // Mostly tiny images; now and then an empty one, or a large RLE
            // image where long repeats expand to dozens of words
            roll = $urandom_range(99);
            if (roll < 8) begin
                w = 16'($urandom);
                h = 16'($urandom);
                if (roll[0]) w = '0;
                else         h = '0;
            end else if (roll < 18 && kind == tpsd_pkg::RLE_KIND) begin
                w = 16'd16;
                h = 16'd16;
            end else begin
                w = 16'($urandom_range(1, 5));
                h = 16'($urandom_range(1, 3));
            end
            total = 32'(w) * 32'(h);

            if (kind == tpsd_pkg::RLE_KIND) begin
                supported = (depth == tpsd_pkg::BPP_24 || depth == tpsd_pkg::BPP_32);
            end else begin
                supported = (depth == tpsd_pkg::BPP_16 || depth == tpsd_pkg::BPP_24 ||
                             depth == tpsd_pkg::BPP_32);
            end

            put_header(kind, w, h, depth, id_bytes);

            if (supported && total > 0) begin
                if (kind == tpsd_pkg::RLE_KIND) begin
                    left = total;
                    while (left > 0) begin
                        roll = $urandom_range(99);
                        if (roll < 12)
                            cnt = $urandom_range(1, 128);     // may overrun the image
                        else if (roll < 55)
                            cnt = $urandom_range(1, (left < 128) ? left : 128);
                        else
                            cnt = $urandom_range(1, ((left < 6) ? left : 6) +
                                                    ((roll >= 92) ? 3 : 0));
                        if (roll < 55) begin
                            file_bytes.push_back(8'(cnt + 127));
                            put_pixel(depth);
                        end else begin
                            // raw packet: only the pixels that still fit follow
                            file_bytes.push_back(8'(cnt - 1));
                            repeat ((cnt < left) ? cnt : left) put_pixel(depth);
                        end
                        left = left - ((cnt < left) ? cnt : left);
                    end
                end else begin
                    repeat (total) put_pixel(depth);
                end
            end

            // Break some files short, trail noise after others
            if ($urandom_range(99) < 12)
                repeat ($urandom_range(1, 6))
                    if (file_bytes.size() > 1) void'(file_bytes.pop_back());
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));

            play_file($urandom_range(99) < 95);
        end

        // Drain: stop stalling so stray words are taken and flagged
        i_valid  <= 1'b0;
        stall_pct = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tga_pixel_stream_decoder_unit regression: pass");
        end else begin
            $display("tga_pixel_stream_decoder_unit regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tga_pixel_stream_decoder_unit regression: fail");
        $finish;
    end

endmodule

/* tga_pixel_stream_decoder_unit.f */
hdl/tpsd_pkg.sv
hdl/tpsd_front.sv
hdl/tpsd_queue.sv
hdl/tpsd_back.sv
hdl/tga_pixel_stream_decoder_unit.sv
sim/tpsd_stream_check.sv
sim/tb.sv
